@@ rtl/brr_pkg.sv @@
`timescale 1ns / 1ps

package brr_pkg;

    // Width of an internal size value, wide enough for the largest store size.
    localparam int SZ_W = 13;
    localparam int COORD_W = 18;
    localparam int POS_W = 21;
    localparam int PIX_W = 16;
    localparam int WGT_W = 16;

    // Configuration register indexes.
    localparam logic REG_IMAGE_WIDTH = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    // Request kinds carried on tuser.
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    // Neighbor selection and fractions for one channel of one sample.
    typedef struct packed {
        logic       x0p;
        logic       x1p;
        logic       y0p;
        logic       y1p;
        logic [7:0] fx;
        logic [7:0] fy;
    } tap_t;

    // A zero size counts as one, a size above the store counts as the store size.
    function automatic logic [SZ_W-1:0] clamp_size(input logic [8:0] v,
                                                   input logic [SZ_W-1:0] maxv);
        logic [SZ_W-1:0] ext;
        ext = SZ_W'(v);
        if (ext == '0) begin
            return SZ_W'(1);
        end else if (ext > maxv) begin
            return maxv;
        end
        return ext;
    endfunction

    // Clamps a coordinate in 1/256 pixel to [0, (size-1)*256].
    function automatic logic [POS_W-1:0] clamp_pos(input logic [COORD_W-1:0] p,
                                                   input logic [SZ_W-1:0] size);
        logic [POS_W-1:0] top;
        logic [POS_W-1:0] pe;
        top = {size - SZ_W'(1), 8'h00};
        pe = POS_W'(p[COORD_W-2:0]);
        if (p[COORD_W-1]) begin
            return '0;
        end else if (pe > top) begin
            return top;
        end
        return pe;
    endfunction

endpackage

@@ rtl/brr_addr.sv @@
`timescale 1ns / 1ps

module brr_addr #(
    parameter int MAX_WIDTH = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int XH = 7,
    parameter int YH = 7
) (
    input  logic [brr_pkg::COORD_W-1:0] pos_x,
    input  logic [brr_pkg::COORD_W-1:0] pos_y,
    input  logic [brr_pkg::SZ_W-1:0]    size_w,
    input  logic [brr_pkg::SZ_W-1:0]    size_h,
    output logic [XH+YH-1:0]            rd_addr [4],
    output brr_pkg::tap_t               tap
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);

    logic [brr_pkg::POS_W-1:0] cx, cy;
    logic [XW-1:0] x0, x1;
    logic [YW-1:0] y0, y1;
    logic          x_step, y_step;
    logic [XH-1:0] col_half [2];
    logic [YH-1:0] row_half [2];

    always_comb begin
        cx = brr_pkg::clamp_pos(pos_x, size_w);
        cy = brr_pkg::clamp_pos(pos_y, size_h);
        x_step = (cx[brr_pkg::POS_W-1:8] + brr_pkg::SZ_W'(1)) < size_w;
        y_step = (cy[brr_pkg::POS_W-1:8] + brr_pkg::SZ_W'(1)) < size_h;
        x0 = XW'(cx[brr_pkg::POS_W-1:8]);
        y0 = YW'(cy[brr_pkg::POS_W-1:8]);
        x1 = x0 + XW'(x_step);
        y1 = y0 + YW'(y_step);
        // Each parity bank holds exactly one of the two columns (rows) needed.
        for (int b = 0; b < 2; b++) begin
            col_half[b] = (x0[0] == b[0]) ? XH'(x0 >> 1) : XH'(x1 >> 1);
            row_half[b] = (y0[0] == b[0]) ? YH'(y0 >> 1) : YH'(y1 >> 1);
        end
        for (int k = 0; k < 4; k++) begin
            rd_addr[k] = {row_half[k / 2], col_half[k % 2]};
        end
        tap.x0p = x0[0];
        tap.x1p = x1[0];
        tap.y0p = y0[0];
        tap.y1p = y1[0];
        tap.fx = cx[7:0];
        tap.fy = cy[7:0];
    end

endmodule

@@ rtl/brr_bank_mem.sv @@
`timescale 1ns / 1ps

module brr_bank_mem #(
    parameter int AW = 14
) (
    input  logic                       aclk,
    input  logic                       rd_en,
    input  logic                       wr_en,
    input  logic [1:0]                 wr_bank,
    input  logic [AW-1:0]              wr_addr,
    input  logic [brr_pkg::PIX_W-1:0]  wr_data,
    input  logic [AW-1:0]              rd_addr [4],
    output logic [brr_pkg::PIX_W-1:0]  rd_data [4]
);

    // Four banks split by column and row parity; bank index is {row[0], col[0]}.
    for (genvar k = 0; k < 4; k++) begin : g_bank
        logic [brr_pkg::PIX_W-1:0] mem [2**AW];
        logic [brr_pkg::PIX_W-1:0] rd_reg;

        always_ff @(posedge aclk) begin
            if (wr_en && (wr_bank == 2'(k))) begin
                mem[wr_addr] <= wr_data;
            end
            if (rd_en) begin
                rd_reg <= mem[rd_addr[k]];
            end
        end

        assign rd_data[k] = rd_reg;
    end

endmodule

@@ rtl/brr_interp.sv @@
`timescale 1ns / 1ps

module brr_interp (
    input  logic                      aclk,
    input  logic                      en,
    input  brr_pkg::tap_t             tap,
    input  logic [brr_pkg::PIX_W-1:0] rd_data [4],
    output logic [brr_pkg::PIX_W-1:0] result
);

    logic [brr_pkg::PIX_W-1:0] pix_reg [4];
    logic [brr_pkg::WGT_W-1:0] wgt_reg [4];
    logic [31:0]               prod_reg [4];
    logic [brr_pkg::PIX_W-1:0] result_reg;
    logic [brr_pkg::PIX_W-1:0] pix_next [4];
    logic [brr_pkg::WGT_W-1:0] wgt_next [4];
    logic [8:0]                gx, gy;
    logic [33:0]               sum;

    always_comb begin
        gx = 9'd256 - 9'(tap.fx);
        gy = 9'd256 - 9'(tap.fy);
        wgt_next[0] = brr_pkg::WGT_W'((18'(gx) * 18'(gy)) >> 1);
        wgt_next[1] = brr_pkg::WGT_W'((18'(tap.fx) * 18'(gy)) >> 1);
        wgt_next[2] = brr_pkg::WGT_W'((18'(gx) * 18'(tap.fy)) >> 1);
        wgt_next[3] = brr_pkg::WGT_W'((18'(tap.fx) * 18'(tap.fy)) >> 1);
        pix_next[0] = rd_data[{tap.y0p, tap.x0p}];
        pix_next[1] = rd_data[{tap.y0p, tap.x1p}];
        pix_next[2] = rd_data[{tap.y1p, tap.x0p}];
        pix_next[3] = rd_data[{tap.y1p, tap.x1p}];
        sum = 34'(prod_reg[0]) + 34'(prod_reg[1]) + 34'(prod_reg[2])
            + 34'(prod_reg[3]) + 34'd16384;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 4; k++) begin
                pix_reg[k] <= pix_next[k];
                wgt_reg[k] <= wgt_next[k];
                prod_reg[k] <= 32'(pix_reg[k]) * 32'(wgt_reg[k]);
            end
            result_reg <= sum[30:15];
        end
    end

    assign result = result_reg;

endmodule

@@ rtl/bilinear_rgb_resampler_unit.sv @@
`timescale 1ns / 1ps
// A sample transaction's result reaches m_tdata through these registered stages in order: store read,
// neighbor select and weights, products, sum and rounding.
// Throughput: one transaction per cycle while the output is not stalled; each channel reads its four
// neighbors at once from four parity banks, so the store read port never limits the rate.
// Reset (aresetn low, synchronous) empties the pipeline and sets both sizes to 256, or to the
// store size where that is smaller; the pixel store is not cleared.

module bilinear_rgb_resampler_unit #(
    parameter int MAX_WIDTH = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic         aclk,
    input  logic         aresetn,
    // Configuration write port.
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [8:0]   cfg_wdata,
    // Request channel.
    input  logic         s_tvalid,
    output logic         s_tready,
    // s_tdata from bit 0: write_col, write_row, write_red, write_green, write_blue,
    // red_x, red_y, green_x, green_y, blue_x, blue_y, then zero fill.
    input  logic [175:0] s_tdata,
    // s_tuser: func (0 writes a pixel, 1 requests a sample).
    input  logic [0:0]   s_tuser,
    // Result channel.
    output logic         m_tvalid,
    input  logic         m_tready,
    // m_tdata from bit 0: out_red, out_green, out_blue.
    output logic [47:0]  m_tdata
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int XH = (XW > 1) ? XW - 1 : 1;
    localparam int YH = (YW > 1) ? YW - 1 : 1;
    localparam int AW = XH + YH;
    localparam logic [brr_pkg::SZ_W-1:0] MAX_W_SZ = brr_pkg::SZ_W'(MAX_WIDTH);
    localparam logic [brr_pkg::SZ_W-1:0] MAX_H_SZ = brr_pkg::SZ_W'(MAX_HEIGHT);

    // Sizes are held already clamped to the legal range.
    logic [brr_pkg::SZ_W-1:0] width_reg, height_reg;

    // Valid bits of the pipeline: store read, weights, products; the last one is m_tvalid.
    logic v1_reg, v2_reg, v3_reg, out_valid_reg;

    // The whole pipeline moves together; it stops only while a result waits at the output.
    logic adv, acc, is_write, is_sample;
    assign adv = !out_valid_reg || m_tready;
    assign acc = s_tvalid && adv;
    assign s_tready = adv;
    assign is_write = acc && (s_tuser[0] == brr_pkg::FUNC_WRITE);
    assign is_sample = acc && (s_tuser[0] == brr_pkg::FUNC_SAMPLE);

    // Input field unpacking.
    logic [7:0]  write_col, write_row;
    logic [15:0] write_pix [3];
    logic [17:0] pos_x [3], pos_y [3];

    always_comb begin
        write_col = s_tdata[7:0];
        write_row = s_tdata[15:8];
        for (int c = 0; c < 3; c++) begin
            write_pix[c] = s_tdata[16 + 16*c +: 16];
            pos_x[c] = s_tdata[64 + 36*c +: 18];
            pos_y[c] = s_tdata[82 + 36*c +: 18];
        end
    end

    // A write outside the store is dropped; inside, it goes to the parity bank of its pixel.
    logic          wr_in_range;
    logic [XW-1:0] wr_x;
    logic [YW-1:0] wr_y;
    logic [AW-1:0] wr_addr;
    logic [1:0]    wr_bank;

    always_comb begin
        wr_in_range = (32'(write_col) < 32'(MAX_WIDTH)) && (32'(write_row) < 32'(MAX_HEIGHT));
        wr_x = XW'(write_col);
        wr_y = YW'(write_row);
        wr_addr = {YH'(wr_y >> 1), XH'(wr_x >> 1)};
        wr_bank = {wr_y[0], wr_x[0]};
    end

    logic [brr_pkg::PIX_W-1:0] chan_result [3];
    brr_pkg::tap_t             tap_reg [3];

    // One independent address path, bank set and interpolator for each color channel,
    // since each channel samples at its own coordinate.
    for (genvar c = 0; c < 3; c++) begin : g_chan
        logic [AW-1:0]             rd_addr [4];
        logic [brr_pkg::PIX_W-1:0] rd_data [4];
        brr_pkg::tap_t             tap_next;

        brr_addr #(
            .MAX_WIDTH  (MAX_WIDTH),
            .MAX_HEIGHT (MAX_HEIGHT),
            .XH         (XH),
            .YH         (YH)
        ) u_addr (
            .pos_x   (pos_x[c]),
            .pos_y   (pos_y[c]),
            .size_w  (width_reg),
            .size_h  (height_reg),
            .rd_addr (rd_addr),
            .tap     (tap_next)
        );

        brr_bank_mem #(
            .AW (AW)
        ) u_mem (
            .aclk    (aclk),
            .rd_en   (adv),
            .wr_en   (is_write && wr_in_range),
            .wr_bank (wr_bank),
            .wr_addr (wr_addr),
            .wr_data (write_pix[c]),
            .rd_addr (rd_addr),
            .rd_data (rd_data)
        );

        // The tap travels alongside the store read so it lines up with the read data.
        always_ff @(posedge aclk) begin
            if (adv) begin
                tap_reg[c] <= tap_next;
            end
        end

        brr_interp u_interp (
            .aclk    (aclk),
            .en      (adv),
            .tap     (tap_reg[c]),
            .rd_data (rd_data),
            .result  (chan_result[c])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg <= brr_pkg::clamp_size(9'd256, MAX_W_SZ);
            height_reg <= brr_pkg::clamp_size(9'd256, MAX_H_SZ);
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    brr_pkg::REG_IMAGE_WIDTH: begin
                        width_reg <= brr_pkg::clamp_size(cfg_wdata, MAX_W_SZ);
                    end
                    brr_pkg::REG_IMAGE_HEIGHT: begin
                        height_reg <= brr_pkg::clamp_size(cfg_wdata, MAX_H_SZ);
                    end
                    default: begin
                        width_reg <= width_reg;
                    end
                endcase
            end
            // Only sample transactions enter the result pipeline; writes leave no trace there.
            if (adv) begin
                v1_reg <= is_sample;
                v2_reg <= v1_reg;
                v3_reg <= v2_reg;
                out_valid_reg <= v3_reg;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = {chan_result[2], chan_result[1], chan_result[0]};

    // A pixel write must never start a result.
    a_write_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser[0] == brr_pkg::FUNC_WRITE)) |=> !v1_reg)
        else $error("pixel write entered the result pipeline");

    // A sample accepted enters the pipeline at the next edge.
    a_sample_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser[0] == brr_pkg::FUNC_SAMPLE)) |=> v1_reg)
        else $error("accepted sample lost at pipeline entry");

    // A result held at a stalled output keeps the rest of the pipeline frozen.
    a_stall_freeze: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> ($stable(v3_reg) && $stable(v2_reg) && $stable(v1_reg)))
        else $error("pipeline moved while the output was stalled");

    // Sizes stay within the store.
    a_size_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (width_reg != '0) && (width_reg <= MAX_W_SZ) && (height_reg != '0)
        && (height_reg <= MAX_H_SZ))
        else $error("image size outside the store");

endmodule
